@@ hw/rtl/pcwc_pkg.sv @@
// ----------------------------------------------------------------------------
// pcwc_pkg: shared types and constants of the pipe channel wake controller.
// Register offsets, command codes, error codes and the queue word format.
// ----------------------------------------------------------------------------
package pcwc_pkg;

  localparam int NUM_PIPES = 16;
  localparam int SLOT_W    = $clog2(NUM_PIPES);
  localparam int CNT_W     = $clog2(NUM_PIPES + 1);

  // Item kinds.
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WAKE  = 2'd2;
  localparam logic [1:0] KIND_CLOSE = 2'd3;

  // Register offsets.
  localparam logic [5:0] OFF_CMD    = 6'h00;
  localparam logic [5:0] OFF_STATUS = 6'h04;
  localparam logic [5:0] OFF_CH_LO  = 6'h08;
  localparam logic [5:0] OFF_SIZE   = 6'h0c;
  localparam logic [5:0] OFF_ADR_LO = 6'h10;
  localparam logic [5:0] OFF_WAKES  = 6'h14;
  localparam logic [5:0] OFF_VER    = 6'h24;
  localparam logic [5:0] OFF_CH_HI  = 6'h30;
  localparam logic [5:0] OFF_ADR_HI = 6'h34;

  // Guest commands.
  localparam logic [31:0] OPC_OPEN     = 32'd1;
  localparam logic [31:0] OPC_CLOSE    = 32'd2;
  localparam logic [31:0] OPC_POLL     = 32'd3;
  localparam logic [31:0] OPC_SEND     = 32'd4;
  localparam logic [31:0] OPC_WAKE_WR  = 32'd5;
  localparam logic [31:0] OPC_RECV     = 32'd6;
  localparam logic [31:0] OPC_WAKE_RD  = 32'd7;

  // Backend request codes.
  localparam logic [2:0] BOP_NONE  = 3'd0;
  localparam logic [2:0] BOP_OPEN  = 3'd1;
  localparam logic [2:0] BOP_CLOSE = 3'd2;
  localparam logic [2:0] BOP_POLL  = 3'd3;
  localparam logic [2:0] BOP_RECV  = 3'd4;
  localparam logic [2:0] BOP_SEND  = 3'd5;
  localparam logic [2:0] BOP_WAKE  = 3'd6;

  localparam logic [31:0] ERR_INVAL = 32'hFFFF_FFFF;
  localparam logic [31:0] ERR_IO    = 32'hFFFF_FFFC;
  localparam logic [31:0] VERSION   = 32'd1;

  // One classified word from the front to the back.
  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  offset;
    logic [31:0] wdata;
    logic [63:0] ev_channel;
    logic [2:0]  ev_flags;
    logic [31:0] bstatus;
  } item_t;

  localparam int QDEPTH = 2;

endpackage

@@ hw/rtl/pcwc_front.sv @@
// ----------------------------------------------------------------------------
// pcwc_front: command front end.
// Accepts words from the command port and queues them for the back end.
// ----------------------------------------------------------------------------
module pcwc_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pcwc_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output pcwc_pkg::item_t head
);
  import pcwc_pkg::*;

  item_t q_r [QDEPTH];
  logic  wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full      = (cnt_r == 2'(QDEPTH));
  assign not_empty = (cnt_r != 2'd0);
  assign head      = q_r[rp_r];

  // Two-entry queue of classified words.
  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= push_item;
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule

@@ hw/rtl/pcwc_back.sv @@
// ----------------------------------------------------------------------------
// pcwc_back: command execution.
// Looks up channels, updates slot table and signal stack, builds the result.
// ----------------------------------------------------------------------------
module pcwc_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            avail,
  input  pcwc_pkg::item_t it,
  output logic            take,
  output logic            out_valid,
  output logic [31:0]     out_read_data,
  output logic            out_irq,
  output logic [2:0]      out_backend_op,
  output logic [63:0]     out_backend_channel,
  output logic [63:0]     out_backend_address,
  output logic [31:0]     out_backend_size,
  output logic [2:0]      out_backend_wake_mask
);
  import pcwc_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EXEC, S_UNLINK} state_t;

  state_t state_r;
  item_t  it_r;
  logic [SLOT_W-1:0] idx_r;
  logic hit_r, free_ok_r;
  logic [SLOT_W-1:0] hit_slot_r, free_slot_r;
  logic [SLOT_W-1:0] ul_slot_r;
  logic [CNT_W-1:0]  rd_r, wr_r;

  logic [NUM_PIPES-1:0] valid_r, closed_r;
  logic [2:0]  wanted_r [NUM_PIPES];
  logic [63:0] chan_mem [NUM_PIPES];
  logic [SLOT_W-1:0] stack_r [NUM_PIPES];
  logic [NUM_PIPES-1:0] onstk_r;
  logic [CNT_W-1:0] count_r;
  logic cvalid_r;
  logic [SLOT_W-1:0] cslot_r;
  logic [63:0] xaddr_r, chword_r;
  logic [31:0] xsize_r, status_r;
  logic [2:0]  wakes_r;
  logic        irq_r;

  logic [63:0] key;
  logic        match;
  logic [SLOT_W-1:0] top;

  assign key   = (it_r.kind == KIND_WRITE) ? chword_r : it_r.ev_channel;
  assign match = valid_r[idx_r] && (chan_mem[idx_r] == key);
  assign top   = stack_r[count_r[SLOT_W-1:0] - SLOT_W'(1)];
  assign take  = (state_r == S_IDLE) && avail;
  assign out_irq = irq_r;

  // Scan sequencer, executor and result register.
  always_ff @(posedge clk) begin
    logic hit_on_stack;
    logic [SLOT_W-1:0] s;
    logic [SLOT_W-1:0] ps;
    logic got;
    logic [2:0] bit_m;
    logic [2:0] nw;
    hit_on_stack = 1'b0;
    s = hit_slot_r;
    ps = '0;
    got = 1'b0;
    bit_m = 3'd0;
    nw = 3'd0;
    out_valid <= 1'b0;
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0; closed_r <= '0; onstk_r <= '0;
      for (int i = 0; i < NUM_PIPES; i++) wanted_r[i] <= 3'd0;
      count_r <= '0; cvalid_r <= 1'b0; cslot_r <= '0;
      xaddr_r <= '0; chword_r <= '0; xsize_r <= '0; status_r <= '0;
      wakes_r <= '0; irq_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: if (avail) begin
          it_r <= it; idx_r <= '0; hit_r <= 1'b0; free_ok_r <= 1'b0;
          state_r <= S_SCAN;
        end
        // One slot compared per cycle.
        S_SCAN: begin
          if (match && !hit_r) begin hit_r <= 1'b1; hit_slot_r <= idx_r; end
          if (!valid_r[idx_r] && !free_ok_r) begin
            free_ok_r <= 1'b1; free_slot_r <= idx_r;
          end
          idx_r <= idx_r + SLOT_W'(1);
          if (idx_r == SLOT_W'(NUM_PIPES - 1)) state_r <= S_EXEC;
        end
        S_EXEC: begin
          state_r <= S_IDLE;
          out_valid <= 1'b1;
          out_read_data <= '0; out_backend_op <= BOP_NONE;
          out_backend_channel <= '0; out_backend_address <= '0;
          out_backend_size <= '0; out_backend_wake_mask <= '0;
          hit_on_stack = onstk_r[s] || (cvalid_r && cslot_r == s);
          case (it_r.kind)
            KIND_WRITE: begin
              case (it_r.offset)
                OFF_SIZE:   xsize_r <= it_r.wdata;
                OFF_ADR_LO: xaddr_r[31:0] <= it_r.wdata;
                OFF_ADR_HI: xaddr_r[63:32] <= it_r.wdata;
                OFF_CH_LO:  chword_r[31:0] <= it_r.wdata;
                OFF_CH_HI:  chword_r[63:32] <= it_r.wdata;
                OFF_CMD: begin
                  if (it_r.wdata != OPC_OPEN && !hit_r) status_r <= ERR_INVAL;
                  else if (hit_r && closed_r[s] && it_r.wdata != OPC_CLOSE)
                    status_r <= ERR_IO;
                  else begin
                    case (it_r.wdata) inside
                      OPC_OPEN: begin
                        if (hit_r || !free_ok_r) status_r <= ERR_INVAL;
                        else begin
                          valid_r[free_slot_r] <= 1'b1;
                          closed_r[free_slot_r] <= 1'b0;
                          wanted_r[free_slot_r] <= 3'd0;
                          chan_mem[free_slot_r] <= chword_r;
                          status_r <= '0;
                          out_backend_op <= BOP_OPEN;
                          out_backend_channel <= chword_r;
                        end
                      end
                      OPC_CLOSE: begin
                        valid_r[s] <= 1'b0; closed_r[s] <= 1'b0;
                        wanted_r[s] <= 3'd0;
                        if (cvalid_r && cslot_r == s) cvalid_r <= 1'b0;
                        out_backend_op <= BOP_CLOSE;
                        out_backend_channel <= chword_r;
                        if (onstk_r[s]) begin
                          // Compact the stack over the following cycles.
                          out_valid <= 1'b0;
                          ul_slot_r <= s; rd_r <= '0; wr_r <= '0;
                          state_r <= S_UNLINK;
                        end
                      end
                      OPC_POLL: begin
                        status_r <= it_r.bstatus;
                        out_backend_op <= BOP_POLL;
                        out_backend_channel <= chword_r;
                      end
                      OPC_SEND, OPC_RECV: begin
                        status_r <= it_r.bstatus;
                        out_backend_op <= (it_r.wdata == OPC_RECV) ? BOP_RECV : BOP_SEND;
                        out_backend_channel <= chword_r;
                        out_backend_address <= xaddr_r;
                        out_backend_size <= xsize_r;
                      end
                      OPC_WAKE_WR, OPC_WAKE_RD: begin
                        bit_m = (it_r.wdata == OPC_WAKE_RD) ? 3'd2 : 3'd4;
                        if ((wanted_r[s] & bit_m) == 3'd0) begin
                          wanted_r[s] <= wanted_r[s] | bit_m;
                          out_backend_op <= BOP_WAKE;
                          out_backend_channel <= chword_r;
                          out_backend_wake_mask <= wanted_r[s] | bit_m;
                        end
                        status_r <= '0;
                      end
                      default: ;
                    endcase
                  end
                end
                default: ;
              endcase
            end
            KIND_READ: begin
              case (it_r.offset) inside
                OFF_STATUS: out_read_data <= status_r;
                OFF_WAKES:  out_read_data <= {29'd0, wakes_r};
                OFF_VER: begin
                  out_read_data <= VERSION;
                  valid_r <= '0; closed_r <= '0; onstk_r <= '0;
                  for (int i = 0; i < NUM_PIPES; i++) wanted_r[i] <= 3'd0;
                  count_r <= '0; cvalid_r <= 1'b0; cslot_r <= '0; irq_r <= 1'b0;
                end
                OFF_CH_LO, OFF_CH_HI: begin
                  if (cvalid_r) begin
                    got = 1'b1; ps = cslot_r; cvalid_r <= 1'b0;
                  end else if (count_r != '0) begin
                    got = 1'b1; ps = top;
                    count_r <= count_r - CNT_W'(1);
                    onstk_r[top] <= 1'b0;
                  end
                  if (!got) irq_r <= 1'b0;
                  else if (it_r.offset == OFF_CH_LO) begin
                    wakes_r <= wanted_r[ps];
                    wanted_r[ps] <= 3'd0;
                    out_read_data <= chan_mem[ps][31:0];
                  end else begin
                    cvalid_r <= 1'b1; cslot_r <= ps;
                    out_read_data <= chan_mem[ps][63:32];
                  end
                end
                default: ;
              endcase
            end
            default: begin
              // Host wake or host close.
              if (hit_r && (it_r.kind == KIND_WAKE || !closed_r[s])) begin
                nw = (it_r.kind == KIND_WAKE) ? it_r.ev_flags : 3'd1;
                if (it_r.kind == KIND_CLOSE) closed_r[s] <= 1'b1;
                wanted_r[s] <= wanted_r[s] | nw;
                if (!hit_on_stack && count_r < CNT_W'(NUM_PIPES)) begin
                  stack_r[count_r[SLOT_W-1:0]] <= s;
                  onstk_r[s] <= 1'b1;
                  count_r <= count_r + CNT_W'(1);
                end
                irq_r <= 1'b1;
              end
            end
          endcase
        end
        // Drop the closed slot from the stack, one entry per cycle.
        S_UNLINK: begin
          if (rd_r == count_r) begin
            count_r <= wr_r; onstk_r[ul_slot_r] <= 1'b0;
            out_valid <= 1'b1; state_r <= S_IDLE;
          end else begin
            if (stack_r[rd_r[SLOT_W-1:0]] != ul_slot_r) begin
              stack_r[wr_r[SLOT_W-1:0]] <= stack_r[rd_r[SLOT_W-1:0]];
              wr_r <= wr_r + CNT_W'(1);
            end
            rd_r <= rd_r + CNT_W'(1);
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

@@ hw/rtl/pipe_channel_wake_controller.sv @@
// ----------------------------------------------------------------------------
// pipe_channel_wake_controller: register front of a virtual pipe device.
// A word passes from the two-entry front queue through the slot scan (S_SCAN)
// to S_EXEC, which registers the result; a close of a signalled channel adds
// stack compaction (S_UNLINK). The queue accepts words while the back end works.
// Synchronous active-low reset clears all slots, the stack and registers;
// busy stays high while reset is held.
// The receiver cannot stall: out_valid is high for one cycle per word.
// ----------------------------------------------------------------------------
module pipe_channel_wake_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [5:0]  in_reg_offset,
  input  logic [31:0] in_write_data,
  input  logic [63:0] in_event_channel,
  input  logic [2:0]  in_event_flags,
  input  logic signed [31:0] in_backend_status,
  output logic        out_valid,
  output logic [31:0] out_read_data,
  output logic        out_irq,
  output logic [2:0]  out_backend_op,
  output logic [63:0] out_backend_channel,
  output logic [63:0] out_backend_address,
  output logic [31:0] out_backend_size,
  output logic [2:0]  out_backend_wake_mask
);
  import pcwc_pkg::*;

  item_t in_item, head;
  logic  full, not_empty, take;

  assign in_item = '{kind: in_kind, offset: in_reg_offset, wdata: in_write_data,
                     ev_channel: in_event_channel, ev_flags: in_event_flags,
                     bstatus: in_backend_status};
  assign busy = full || !rst_n;

  pcwc_front u_front (
    .clk(clk), .rst_n(rst_n), .push(start && !busy), .push_item(in_item),
    .full(full), .pop(take), .not_empty(not_empty), .head(head)
  );

  pcwc_back u_back (
    .clk(clk), .rst_n(rst_n), .avail(not_empty), .it(head), .take(take),
    .out_valid(out_valid), .out_read_data(out_read_data),
    .out_irq(out_irq), .out_backend_op(out_backend_op),
    .out_backend_channel(out_backend_channel),
    .out_backend_address(out_backend_address),
    .out_backend_size(out_backend_size),
    .out_backend_wake_mask(out_backend_wake_mask)
  );
endmodule

@@ hw/rtl/pcwc_checker.sv @@
// ----------------------------------------------------------------------------
// pcwc_checker: port-level checks of the pipe channel wake controller.
// Bound to the top level.
// ----------------------------------------------------------------------------
module pcwc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        busy,
  input logic        out_valid,
  input logic [31:0] out_read_data,
  input logic [2:0]  out_backend_op,
  input logic [2:0]  out_backend_wake_mask
);
  import pcwc_pkg::*;

  // A result never shows an undefined backend request code.
  a_op: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_backend_op != 3'd7) else $error("bad backend op");

  // A wake mask appears only with a wake-on request.
  a_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_backend_op != BOP_WAKE |-> out_backend_wake_mask == 3'd0)
    else $error("stray wake mask");

  // Read data only comes with reads, which never make a backend request.
  a_rd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_data != 32'd0 |-> out_backend_op == BOP_NONE)
    else $error("read data with a backend request");

  // Results are single-cycle strobes.
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("back-to-back results");

  // Reset leaves the block ready once it is released.
  a_rst: assert property (@(posedge clk) !rst_n ##1 rst_n |-> !busy && !out_valid)
    else $error("busy after reset");
endmodule

bind pipe_channel_wake_controller pcwc_checker u_pcwc_checker (
  .clk(clk), .rst_n(rst_n), .busy(busy), .out_valid(out_valid),
  .out_read_data(out_read_data), .out_backend_op(out_backend_op),
  .out_backend_wake_mask(out_backend_wake_mask)
);

@@ tb/pipe_channel_wake_controller_test.sv @@
// ----------------------------------------------------------------------------
// Pipe channel wake controller testbench
// Drives guest register accesses and host events through the start/busy
// handshake in random bursts. Every accepted word is run through a predictor
// of the slot table, signal stack and registers kept in the bench. Each
// out_valid word is compared field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module pipe_channel_wake_controller_test;
  import pcwc_pkg::*;

  typedef struct {
    logic [1:0]  kind;
    logic [5:0]  off;
    logic [31:0] wd;
    logic [63:0] ech;
    logic [2:0]  ef;
    logic [31:0] bs;
    bit          has_exp;
    logic [31:0] exp_rd;
    bit          exp_irq;
  } stim_t;

  typedef struct {
    logic [31:0] rd;
    logic        irq;
    logic [2:0]  op;
    logic [63:0] chn;
    logic [63:0] adr;
    logic [31:0] sz;
    logic [2:0]  mask;
  } result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_kind = '0;
  logic [5:0]         in_reg_offset = '0;
  logic [31:0]        in_write_data = '0;
  logic [63:0]        in_event_channel = '0;
  logic [2:0]         in_event_flags = '0;
  logic signed [31:0] in_backend_status = '0;
  logic               out_valid;
  logic [31:0]        out_read_data;
  logic               out_irq;
  logic [2:0]         out_backend_op;
  logic [63:0]        out_backend_channel;
  logic [63:0]        out_backend_address;
  logic [31:0]        out_backend_size;
  logic [2:0]         out_backend_wake_mask;

  pipe_channel_wake_controller dut (.*);

  always #5 clk = ~clk;

  // Predicted device state.
  bit          slot_used[NUM_PIPES];
  logic [63:0] slot_ch[NUM_PIPES];
  bit          slot_shut[NUM_PIPES];
  logic [2:0]  slot_bits[NUM_PIPES];
  int          sig_stk[NUM_PIPES];
  int          sig_cnt;
  bit          cache_v;
  int          cache_s;
  logic [63:0] xfer_adr;
  logic [31:0] xfer_sz;
  logic [31:0] status_reg;
  logic [63:0] chan_reg;
  logic [2:0]  wakes_reg;
  bit          irq_lvl;

  result_t     pending_results[$];
  stim_t       accepted_word;
  stim_t       rows[$];
  stim_t       pending_word[$];
  int          fails = 0;
  int          burst_left;
  logic [63:0] chan_pool[20];

  function automatic int find_chan(logic [63:0] c);
    for (int i = 0; i < NUM_PIPES; i++)
      if (slot_used[i] && slot_ch[i] == c) return i;
    return -1;
  endfunction

  function automatic bit stacked(int s);
    for (int i = 0; i < sig_cnt; i++)
      if (sig_stk[i] == s) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void drop_all();
    for (int i = 0; i < NUM_PIPES; i++) begin
      slot_used[i] = 0;
      slot_shut[i] = 0;
      slot_bits[i] = '0;
    end
    sig_cnt = 0;
    cache_v = 0;
    cache_s = 0;
    irq_lvl = 0;
  endfunction

  function automatic void signal_slot(int s, logic [2:0] f);
    slot_bits[s] = slot_bits[s] | f;
    if (!stacked(s) && !(cache_v && cache_s == s) && sig_cnt < NUM_PIPES) begin
      sig_stk[sig_cnt] = s;
      sig_cnt++;
    end
    irq_lvl = 1;
  endfunction

  function automatic int pop_slot();
    if (cache_v) begin
      cache_v = 0;
      return cache_s;
    end
    if (sig_cnt > 0) begin
      sig_cnt--;
      return sig_stk[sig_cnt];
    end
    return -1;
  endfunction

  // Guest command against the channel register.
  function automatic void run_command(logic [31:0] cmd, logic [31:0] bst,
                                      ref result_t r);
    int s;
    int j;
    logic [2:0] bit_w;
    s = find_chan(chan_reg);
    if (cmd != OPC_OPEN && s < 0) begin
      status_reg = ERR_INVAL;
      return;
    end
    if (s >= 0 && slot_shut[s] && cmd != OPC_CLOSE) begin
      status_reg = ERR_IO;
      return;
    end
    case (cmd) inside
      OPC_OPEN: begin
        if (s >= 0) begin
          status_reg = ERR_INVAL;
          return;
        end
        j = 0;
        while (j < NUM_PIPES && slot_used[j]) j++;
        if (j >= NUM_PIPES) begin
          status_reg = ERR_INVAL;
          return;
        end
        slot_used[j] = 1;
        slot_ch[j] = chan_reg;
        slot_shut[j] = 0;
        slot_bits[j] = '0;
        status_reg = '0;
        r.op = BOP_OPEN;
        r.chn = chan_reg;
      end
      OPC_CLOSE: begin
        // Free the slot and squeeze it out of the stack and the cache.
        if (cache_v && cache_s == s) cache_v = 0;
        j = 0;
        for (int i = 0; i < sig_cnt; i++)
          if (sig_stk[i] != s) begin
            sig_stk[j] = sig_stk[i];
            j++;
          end
        sig_cnt = j;
        slot_used[s] = 0;
        slot_shut[s] = 0;
        slot_bits[s] = '0;
        r.op = BOP_CLOSE;
        r.chn = chan_reg;
      end
      OPC_POLL: begin
        status_reg = bst;
        r.op = BOP_POLL;
        r.chn = chan_reg;
      end
      OPC_SEND, OPC_RECV: begin
        status_reg = bst;
        r.op = (cmd == OPC_RECV) ? BOP_RECV : BOP_SEND;
        r.chn = chan_reg;
        r.adr = xfer_adr;
        r.sz = xfer_sz;
      end
      OPC_WAKE_WR, OPC_WAKE_RD: begin
        bit_w = (cmd == OPC_WAKE_RD) ? 3'b010 : 3'b100;
        if ((slot_bits[s] & bit_w) == '0) begin
          slot_bits[s] = slot_bits[s] | bit_w;
          r.op = BOP_WAKE;
          r.chn = chan_reg;
          r.mask = slot_bits[s];
        end
        status_reg = '0;
      end
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] guest_read(logic [5:0] off);
    int s;
    case (off) inside
      OFF_STATUS: return status_reg;
      OFF_CH_LO, OFF_CH_HI: begin
        s = pop_slot();
        if (s < 0) begin
          irq_lvl = 0;
          return '0;
        end
        if (off == OFF_CH_HI) begin
          cache_v = 1;
          cache_s = s;
          return slot_ch[s][63:32];
        end
        wakes_reg = slot_bits[s];
        slot_bits[s] = '0;
        return slot_ch[s][31:0];
      end
      OFF_WAKES: return {29'd0, wakes_reg};
      OFF_VER: begin
        drop_all();
        return VERSION;
      end
      default: return '0;
    endcase
  endfunction

  // Expected result of one accepted word; updates the predicted state.
  function automatic result_t predict_word(stim_t w);
    result_t r;
    int s;
    r = '{default: '0};
    case (w.kind)
      KIND_WRITE:
        case (w.off)
          OFF_CMD:    run_command(w.wd, w.bs, r);
          OFF_SIZE:   xfer_sz = w.wd;
          OFF_ADR_LO: xfer_adr[31:0] = w.wd;
          OFF_ADR_HI: xfer_adr[63:32] = w.wd;
          OFF_CH_LO:  chan_reg[31:0] = w.wd;
          OFF_CH_HI:  chan_reg[63:32] = w.wd;
          default: ;
        endcase
      KIND_READ: r.rd = guest_read(w.off);
      KIND_WAKE: begin
        s = find_chan(w.ech);
        if (s >= 0) signal_slot(s, w.ef);
      end
      default: begin
        s = find_chan(w.ech);
        if (s >= 0 && !slot_shut[s]) begin
          slot_shut[s] = 1;
          signal_slot(s, 3'b001);
        end
      end
    endcase
    r.irq = irq_lvl;
    if (w.has_exp) begin
      r.rd = w.exp_rd;
      r.irq = w.exp_irq;
    end
    return r;
  endfunction

  function automatic stim_t mk(logic [1:0] k, logic [5:0] o, logic [31:0] d,
                               logic [63:0] c, logic [2:0] f, logic [31:0] b);
    stim_t w;
    w = '{kind: k, off: o, wd: d, ech: c, ef: f, bs: b, has_exp: 0,
          exp_rd: '0, exp_irq: 0};
    return w;
  endfunction

  function automatic stim_t mk_rd(logic [5:0] o, logic [31:0] e, bit q);
    stim_t w;
    w = mk(KIND_READ, o, $urandom, {$urandom, $urandom}, 3'($urandom), $urandom);
    w.has_exp = 1;
    w.exp_rd = e;
    w.exp_irq = q;
    return w;
  endfunction

  // Accept words and check results at the clock edge.
  always @(posedge clk) begin
    result_t e;
    if (rst_n && start && !busy) begin
      accepted_word.kind = in_kind;
      accepted_word.off = in_reg_offset;
      accepted_word.wd = in_write_data;
      accepted_word.ech = in_event_channel;
      accepted_word.ef = in_event_flags;
      accepted_word.bs = in_backend_status;
      accepted_word.has_exp = 0;
      if (pending_word.size() > 0) accepted_word = pending_word.pop_front();
      pending_results.push_back(predict_word(accepted_word));
    end
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result word with no expectation waiting");
        fails++;
      end else begin
        e = pending_results.pop_front();
        if (out_read_data !== e.rd) begin
          $error("read_data exp %h got %h", e.rd, out_read_data); fails++;
        end
        if (out_irq !== e.irq) begin
          $error("irq exp %b got %b", e.irq, out_irq); fails++;
        end
        if (out_backend_op !== e.op) begin
          $error("backend_op exp %0d got %0d", e.op, out_backend_op); fails++;
        end
        if (out_backend_channel !== e.chn) begin
          $error("backend_channel exp %h got %h", e.chn, out_backend_channel);
          fails++;
        end
        if (out_backend_address !== e.adr) begin
          $error("backend_address exp %h got %h", e.adr, out_backend_address);
          fails++;
        end
        if (out_backend_size !== e.sz) begin
          $error("backend_size exp %h got %h", e.sz, out_backend_size); fails++;
        end
        if (out_backend_wake_mask !== e.mask) begin
          $error("backend_wake_mask exp %b got %b", e.mask, out_backend_wake_mask);
          fails++;
        end
      end
    end
  end

  // Present one word and hold it until the handshake takes it.
  task automatic send_word(stim_t w);
    pending_word.push_back(w);
    start <= 1'b1;
    in_kind <= w.kind;
    in_reg_offset <= w.off;
    in_write_data <= w.wd;
    in_event_channel <= w.ech;
    in_event_flags <= w.ef;
    in_backend_status <= w.bs;
    @(posedge clk);
    while (busy) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  function automatic stim_t random_word();
    logic [63:0] c;
    int p;
    c = chan_pool[$urandom_range(0, 19)];
    p = $urandom_range(0, 99);
    if (p < 10) return mk(KIND_WRITE, OFF_CH_LO, c[31:0], c, 3'($urandom), $urandom);
    if (p < 20) return mk(KIND_WRITE, OFF_CH_HI, c[63:32], c, 3'($urandom), $urandom);
    if (p < 45) return mk(KIND_WRITE, OFF_CMD,
                          ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 8),
                          {$urandom, $urandom}, 3'($urandom), $urandom);
    if (p < 50) return mk(KIND_WRITE, $urandom_range(0, 1) ? OFF_SIZE :
                          ($urandom_range(0, 1) ? OFF_ADR_LO : OFF_ADR_HI),
                          $urandom, {$urandom, $urandom}, 3'($urandom), $urandom);
    if (p < 53) return mk(KIND_WRITE, 6'($urandom), $urandom, {$urandom, $urandom},
                          3'($urandom), $urandom);
    if (p < 68) begin
      p = $urandom_range(0, 9);
      return mk(KIND_READ, (p < 4) ? OFF_CH_LO : (p < 6) ? OFF_CH_HI :
                (p < 7) ? OFF_STATUS : (p < 8) ? OFF_WAKES : 6'($urandom),
                $urandom, {$urandom, $urandom}, 3'($urandom), $urandom);
    end
    if (p < 69) return mk(KIND_READ, OFF_VER, $urandom, c, 3'($urandom), $urandom);
    if (p < 88) return mk(KIND_WAKE, 6'($urandom), $urandom,
                          ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : c,
                          3'($urandom), $urandom);
    return mk(KIND_CLOSE, 6'($urandom), $urandom, c, 3'($urandom), $urandom);
  endfunction

  // Stimulus: directed table, then random words.
  initial begin
    logic [63:0] ones;
    ones = '1;
    drop_all();
    xfer_adr = '0;
    xfer_sz = '0;
    status_reg = '0;
    chan_reg = '0;
    wakes_reg = '0;
    burst_left = $urandom_range(1, 30);
    chan_pool[0] = '0;
    chan_pool[1] = ones;
    for (int i = 2; i < 20; i++) chan_pool[i] = {$urandom, $urandom};

    rows.push_back(mk_rd(OFF_STATUS, 32'd0, 0));
    rows.push_back(mk_rd(OFF_CH_LO, 32'd0, 0));
    rows.push_back(mk(KIND_WRITE, OFF_CMD, OPC_POLL, '0, 3'd0, 32'd5));
    rows.push_back(mk_rd(OFF_STATUS, ERR_INVAL, 0));
    rows.push_back(mk(KIND_WRITE, OFF_CH_LO, '1, '0, 3'd7, '1));
    rows.push_back(mk(KIND_WRITE, OFF_CH_HI, '1, '0, 3'd0, '0));
    rows.push_back(mk(KIND_WRITE, OFF_CMD, OPC_OPEN, '0, 3'd0, '0));
    rows.push_back(mk(KIND_WRITE, OFF_CMD, OPC_OPEN, '0, 3'd0, '0));
    rows.push_back(mk(KIND_WRITE, OFF_SIZE, '1, '0, 3'd0, '0));
    rows.push_back(mk(KIND_WRITE, OFF_ADR_LO, 32'h8000_0001, '0, 3'd0, '0));
    rows.push_back(mk(KIND_WRITE, OFF_ADR_HI, '1, '0, 3'd0, '0));
    rows.push_back(mk(KIND_WRITE, OFF_CMD, OPC_SEND, '0, 3'd0, 32'h7FFF_FFFF));
    rows.push_back(mk(KIND_WRITE, OFF_CMD, OPC_RECV, '0, 3'd0, 32'h8000_0000));
    rows.push_back(mk(KIND_WRITE, OFF_CMD, OPC_POLL, '0, 3'd0, '1));
    rows.push_back(mk(KIND_WRITE, OFF_CMD, OPC_WAKE_WR, '0, 3'd0, '0));
    rows.push_back(mk(KIND_WRITE, OFF_CMD, OPC_WAKE_WR, '0, 3'd0, '0));
    rows.push_back(mk(KIND_WRITE, OFF_CMD, OPC_WAKE_RD, '0, 3'd0, '0));
    rows.push_back(mk(KIND_WRITE, OFF_CMD, 32'd0, '0, 3'd0, '0));
    rows.push_back(mk(KIND_WAKE, '0, '0, ones, 3'd7, '0));
    rows.push_back(mk(KIND_WAKE, '0, '0, ones, 3'd2, '0));
    rows.push_back(mk_rd(OFF_CH_HI, '1, 1));
    rows.push_back(mk_rd(OFF_CH_LO, '1, 1));
    rows.push_back(mk(KIND_READ, OFF_WAKES, '0, '0, 3'd0, '0));
    rows.push_back(mk(KIND_CLOSE, '0, '0, ones, 3'd0, '0));
    rows.push_back(mk(KIND_WRITE, OFF_CMD, OPC_POLL, '0, 3'd0, '0));
    rows.push_back(mk(KIND_WRITE, OFF_CMD, OPC_CLOSE, '0, 3'd0, '0));
    rows.push_back(mk(KIND_WRITE, 6'h18, '1, '0, 3'd0, '0));
    rows.push_back(mk_rd(6'h1c, 32'd0, 1));
    rows.push_back(mk_rd(OFF_VER, VERSION, 0));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i]) send_word(rows[i]);
    repeat (400) send_word(random_word());
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fails == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // Run limit.
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
